FILE: src/u2sbt_pkg.sv
// ----------------------------------------------------------------------------
// u2sbt_pkg
// Types, constants and character maps shared by the UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u2sbt_pkg;

   localparam int MaxResults = 6;
   localparam int HeldDepth  = 4;

   localparam logic [7:0] DefaultCp1252 = 8'hA4;
   localparam logic [7:0] DefaultAscii  = 8'h3F;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_of_string;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       string_end;
   } rsp_type;

   // one pending result: raw bytes bypass the map
   typedef struct packed {
      logic        raw;
      logic [30:0] value;
   } entry_type;

   typedef struct packed {
      entry_type [MaxResults-1:0] slot;
      logic [2:0]                 count;
      logic                       last;
   } job_type;

   function automatic logic [2:0] seq_len(input logic [7:0] b);
      logic [2:0] len;
      len = 3'd1;
      if (b[7:5] == 3'b110) len = 3'd2;
      else if (b[7:4] == 4'b1110) len = 3'd3;
      else if (b[7:3] == 5'b11110) len = 3'd4;
      else if (b[7:2] == 6'b111110) len = 3'd5;
      else if (b[7:1] == 7'b1111110) len = 3'd6;
      return len;
   endfunction

   function automatic logic [7:0] map_cp1252(input logic [30:0] v);
      logic [7:0] r;
      r = DefaultCp1252;
      if (v <= 31'hFF) begin
         r = v[7:0];
      end else begin
         unique case (v)
            31'h20AC: r = 8'h80;
            31'h201A: r = 8'h82;
            31'h0192: r = 8'h83;
            31'h201E: r = 8'h84;
            31'h2026: r = 8'h85;
            31'h2020: r = 8'h86;
            31'h2021: r = 8'h87;
            31'h02C6: r = 8'h88;
            31'h2030: r = 8'h89;
            31'h0160: r = 8'h8A;
            31'h2039: r = 8'h8B;
            31'h0152: r = 8'h8C;
            31'h017D: r = 8'h8E;
            31'h2018: r = 8'h91;
            31'h2019: r = 8'h92;
            31'h201C: r = 8'h93;
            31'h201D: r = 8'h94;
            31'h2022: r = 8'h95;
            31'h2013: r = 8'h96;
            31'h2014: r = 8'h97;
            31'h02DC: r = 8'h98;
            31'h2122: r = 8'h99;
            31'h0161: r = 8'h9A;
            31'h203A: r = 8'h9B;
            31'h0153: r = 8'h9C;
            31'h017E: r = 8'h9E;
            31'h0178: r = 8'h9F;
            default:  r = DefaultCp1252;
         endcase
      end
      return r;
   endfunction

   function automatic logic [7:0] map_ascii(input logic [30:0] v);
      logic [7:0] r;
      r = DefaultAscii;
      if (v == 31'h201C || v == 31'h201D) r = 8'h22;
      else if (v == 31'hB4 || v == 31'h2018) r = 8'h60;
      else if (v == 31'h2019) r = 8'h27;
      else if (v >= 31'hF2 && v <= 31'hF6) r = 8'h6F;
      else if (v >= 31'hE0 && v <= 31'hE5) r = 8'h61;
      else if (v >= 31'hE8 && v <= 31'hEB) r = 8'h65;
      else if (v >= 31'hC0 && v <= 31'hC5) r = 8'h41;
      else if (v == 31'hF8) r = 8'h30;
      return r;
   endfunction

endpackage

FILE: src/u2sbt_decode.sv
// ----------------------------------------------------------------------------
// u2sbt_decode
// Sequence tracking state and assembly of the results one byte causes.
// ----------------------------------------------------------------------------
module u2sbt_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  u2sbt_pkg::req_type req_payload,
   output u2sbt_pkg::job_type job
);
   import u2sbt_pkg::*;

   logic [7:0]  lead_ff, lead_in;
   logic [2:0]  exp_len_ff, exp_len_in;
   logic [2:0]  held_count_ff, held_count_in;
   logic [30:0] accum_ff, accum_in;
   logic [7:0]  held_ff [HeldDepth];

   logic [7:0]  b;
   logic        last;
   logic        pending, is_cont, complete, flush, hold, start;
   logic        tail_valid;
   entry_type   tail;
   logic [2:0]  tail_pos, len;
   logic [30:0] accum_next;
   logic [7:0]  lead_mask;

   always_comb begin
      b          = req_payload.in_byte;
      last       = req_payload.last_of_string;
      pending    = (exp_len_ff != 3'd0);
      is_cont    = (b[7:6] == 2'b10);
      accum_next = {accum_ff[24:0], b[5:0]};
      complete   = pending && is_cont &&
                   (({1'b0, held_count_ff} + 4'd2) >= {1'b0, exp_len_ff});
      flush      = pending && (!is_cont || (!complete && last));
      hold       = pending && is_cont && !complete && !last;
      len        = seq_len(b);
      start      = !(pending && is_cont) && b[7] && (len != 3'd1) && !last;
      lead_mask  = 8'h7F >> len;

      tail_valid = 1'b1;
      tail       = '{raw: 1'b0, value: {23'd0, b}};
      if (pending && is_cont) begin
         if (complete) tail.value = accum_next;
         else if (!last) tail_valid = 1'b0;
      end else if (!b[7]) begin
         tail.raw = 1'b1;
      end else if (start) begin
         tail_valid = 1'b0;
      end

      tail_pos = flush ? held_count_ff + 3'd1 : 3'd0;
      for (int i = 0; i < MaxResults; i++) begin
         job.slot[i] = '{raw: 1'b0, value: 31'd0};
         if (flush && i == 0)
            job.slot[i].value = {23'd0, lead_ff};
         else if (flush && i >= 1 && i <= HeldDepth && 3'(i) <= held_count_ff)
            job.slot[i].value = {23'd0, held_ff[2'(i - 1)]};
         else if (tail_valid && 3'(i) == tail_pos)
            job.slot[i] = tail;
      end
      job.count = tail_pos + {2'd0, tail_valid};
      job.last  = last;

      lead_in       = 8'd0;
      exp_len_in    = 3'd0;
      held_count_in = 3'd0;
      accum_in      = 31'd0;
      if (hold) begin
         lead_in       = lead_ff;
         exp_len_in    = exp_len_ff;
         held_count_in = held_count_ff + 3'd1;
         accum_in      = accum_next;
      end else if (start) begin
         lead_in    = b;
         exp_len_in = len;
         accum_in   = {23'd0, b & lead_mask};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff       <= 8'd0;
         exp_len_ff    <= 3'd0;
         held_count_ff <= 3'd0;
         accum_ff      <= 31'd0;
      end else if (accept) begin
         lead_ff       <= lead_in;
         exp_len_ff    <= exp_len_in;
         held_count_ff <= held_count_in;
         accum_ff      <= accum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && hold) held_ff[held_count_ff[1:0]] <= b;
   end

endmodule

FILE: src/u2sbt_emit.sv
// ----------------------------------------------------------------------------
// u2sbt_emit
// Holds one item's results and hands them out, one byte per transfer, mapped unless raw.
// ----------------------------------------------------------------------------
module u2sbt_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               target_mode,
   input  logic               accept,
   input  u2sbt_pkg::job_type job,
   output logic               free,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output u2sbt_pkg::rsp_type rsp_payload
);
   import u2sbt_pkg::*;

   job_type    job_ff;
   logic       job_valid_ff, job_valid_in;
   logic [2:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   entry_type  cur;
   logic       load, final_entry;

   always_comb begin
      cur         = job_ff.slot[idx_ff];
      load        = job_valid_ff && (!rsp_valid_ff || !rsp_stall);
      final_entry = (idx_ff == job_ff.count - 3'd1);
      free        = !job_valid_ff || (load && final_entry);

      rsp_in.out_byte   = cur.raw ? cur.value[7:0] :
                          (target_mode ? map_ascii(cur.value) : map_cp1252(cur.value));
      rsp_in.run_last   = final_entry;
      rsp_in.string_end = final_entry && job_ff.last;

      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

      job_valid_in = job_valid_ff && !free;
      idx_in       = load ? idx_ff + 3'd1 : idx_ff;
      if (accept) begin
         job_valid_in = (job.count != 3'd0);
         idx_in       = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) job_ff <= job;
      if (load)   rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: src/utf8_to_single_byte_transcoder.sv
// ----------------------------------------------------------------------------
// utf8_to_single_byte_transcoder
// Lax UTF-8 decoder emitting one CP1252 or folded ASCII byte per sequence.
// ----------------------------------------------------------------------------
// Input channel req_*: one text byte per transfer, last_of_string on the
// final byte of a string. Result channel rsp_*: converted bytes; run_last
// marks the last byte caused by an input, string_end the last of a string.
// A byte yields zero to six results. csr_write_enable/csr_write_data set the
// target mode (0 CP1252, 1 ASCII folding); write it only while idle.
// The first result of an input passes the holding register and then the
// result register before it is offered. Throughput: one input per cycle
// while each causes at most one result and rsp_stall is low; an input with
// several results keeps req_stall high until its last one is loaded. A held
// rsp_stall backs up into req_stall once the result register and holding
// register are full; nothing is dropped.
// Reset (synchronous) clears any pending sequence, empties the result path
// and selects CP1252 mode.
// ----------------------------------------------------------------------------
module utf8_to_single_byte_transcoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  u2sbt_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output u2sbt_pkg::rsp_type rsp_payload,
   input  logic               csr_write_enable,
   input  logic               csr_write_data
);
   import u2sbt_pkg::*;

   logic    target_mode_ff;
   logic    accept, free;
   job_type job;

   always_ff @(posedge clock) begin
      if (reset) target_mode_ff <= 1'b0;
      else if (csr_write_enable) target_mode_ff <= csr_write_data;
   end

   assign req_stall = !free;
   assign accept    = req_valid && free;

   u2sbt_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_payload (req_payload),
      .job         (job)
   );

   u2sbt_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .target_mode (target_mode_ff),
      .accept      (accept),
      .job         (job),
      .free        (free),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the UTF-8 to single-byte transcoder. A queue-fed
// driver sends text bytes, a predictor decodes each accepted transfer into
// the bytes it should cause, and a monitor checks every result transfer in
// order. Runs directed strings in both modes, then random strings with
// bursty idling, a long receiver hold-off and quiet closing phases.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import u2sbt_pkg::*;

   localparam int CycleLimit = 400000;

   logic    clock            = 1'b0;
   logic    reset            = 1'b1;
   logic    req_valid        = 1'b0;
   logic    req_stall;
   req_type req_payload      = '0;
   logic    rsp_valid;
   logic    rsp_stall        = 1'b0;
   rsp_type rsp_payload;
   logic    csr_write_enable = 1'b0;
   logic    csr_write_data   = 1'b0;

   req_type byte_backlog [$];
   rsp_type expected_chars [$];

   int queued_count   = 0;
   int accepted_count = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;
   int send_gap       = 0;
   int stall_left     = 0;

   bit send_jitter = 1'b0;
   bit recv_jitter = 1'b0;
   bit long_hold   = 1'b0;

   // decoder shadow
   bit          mode_shadow = 1'b0;
   logic [7:0]  open_lead;
   logic [2:0]  open_len;
   logic [2:0]  open_held;
   logic [7:0]  held_bytes [0:3];
   logic [30:0] code_point;

   utf8_to_single_byte_transcoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic logic [2:0] lead_length(input logic [7:0] b);
      casez (b)
         8'b110?????: return 3'd2;
         8'b1110????: return 3'd3;
         8'b11110???: return 3'd4;
         8'b111110??: return 3'd5;
         8'b1111110?: return 3'd6;
         default:     return 3'd1;
      endcase
   endfunction

   function automatic logic [7:0] to_cp1252(input logic [30:0] v);
      if (v < 31'h100) return v[7:0];
      case (v)
         31'h20AC: return 8'h80;
         31'h201A: return 8'h82;
         31'h0192: return 8'h83;
         31'h201E: return 8'h84;
         31'h2026: return 8'h85;
         31'h2020: return 8'h86;
         31'h2021: return 8'h87;
         31'h02C6: return 8'h88;
         31'h2030: return 8'h89;
         31'h0160: return 8'h8A;
         31'h2039: return 8'h8B;
         31'h0152: return 8'h8C;
         31'h017D: return 8'h8E;
         31'h2018: return 8'h91;
         31'h2019: return 8'h92;
         31'h201C: return 8'h93;
         31'h201D: return 8'h94;
         31'h2022: return 8'h95;
         31'h2013: return 8'h96;
         31'h2014: return 8'h97;
         31'h02DC: return 8'h98;
         31'h2122: return 8'h99;
         31'h0161: return 8'h9A;
         31'h203A: return 8'h9B;
         31'h0153: return 8'h9C;
         31'h017E: return 8'h9E;
         31'h0178: return 8'h9F;
         default:  return DefaultCp1252;
      endcase
   endfunction

   function automatic logic [7:0] to_folded(input logic [30:0] v);
      if (v == 31'h201C || v == 31'h201D) return 8'h22;
      if (v == 31'h00B4 || v == 31'h2018) return 8'h60;
      if (v == 31'h2019) return 8'h27;
      if (v >= 31'hF2 && v <= 31'hF6) return 8'h6F;
      if (v >= 31'hE0 && v <= 31'hE5) return 8'h61;
      if (v >= 31'hE8 && v <= 31'hEB) return 8'h65;
      if (v >= 31'hC0 && v <= 31'hC5) return 8'h41;
      if (v == 31'hF8) return 8'h30;
      return DefaultAscii;
   endfunction

   function automatic logic [7:0] map_char(input logic [30:0] v);
      return mode_shadow ? to_folded(v) : to_cp1252(v);
   endfunction

   task automatic emit_char(input logic [7:0] c);
      rsp_type r;
      r.out_byte   = c;
      r.run_last   = 1'b0;
      r.string_end = 1'b0;
      expected_chars.push_back(r);
   endtask

   task automatic close_sequence;
      open_lead  = 8'h00;
      open_len   = 3'd0;
      open_held  = 3'd0;
      code_point = '0;
   endtask

   task automatic flush_sequence;
      emit_char(map_char({23'd0, open_lead}));
      for (int i = 0; i < open_held; i++)
         emit_char(map_char({23'd0, held_bytes[2'(i)]}));
      close_sequence();
   endtask

   task automatic start_byte(input logic [7:0] b, input logic fin);
      logic [2:0] len;
      len = lead_length(b);
      if (b < 8'h80) begin
         emit_char(b);
      end else if (len == 3'd1 || fin) begin
         emit_char(map_char({23'd0, b}));
      end else begin
         open_lead  = b;
         open_len   = len;
         open_held  = 3'd0;
         code_point = {23'd0, b & (8'h7F >> len)};
      end
   endtask

   task automatic transcode_byte(input req_type item);
      logic [7:0] b;
      logic       fin;
      int         before_size;
      rsp_type    tail;
      b           = item.in_byte;
      fin         = item.last_of_string;
      before_size = expected_chars.size();
      if (open_len != 3'd0) begin
         if (b[7:6] == 2'b10) begin
            code_point = {code_point[24:0], b[5:0]};
            if (int'(open_held) + 2 >= int'(open_len)) begin
               emit_char(map_char(code_point));
               close_sequence();
            end else if (fin) begin
               flush_sequence();
               emit_char(map_char({23'd0, b}));
            end else begin
               held_bytes[open_held[1:0]] = b;
               open_held++;
            end
         end else begin
            flush_sequence();
            start_byte(b, fin);
         end
      end else begin
         start_byte(b, fin);
      end
      if (expected_chars.size() > before_size) begin
         tail            = expected_chars.pop_back();
         tail.run_last   = 1'b1;
         tail.string_end = fin;
         expected_chars.push_back(tail);
      end
   endtask

   task automatic flag_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   task automatic check_char(input rsp_type got);
      rsp_type want;
      if (expected_chars.size() == 0) begin
         flag_mismatch($sformatf("unexpected byte %02h", got.out_byte));
         return;
      end
      want = expected_chars.pop_front();
      if (got.out_byte !== want.out_byte)
         flag_mismatch($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
      if (got.run_last !== want.run_last)
         flag_mismatch($sformatf("run_last %b, want %b", got.run_last, want.run_last));
      if (got.string_end !== want.string_end)
         flag_mismatch($sformatf("string_end %b, want %b", got.string_end, want.string_end));
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            transcode_byte(req_payload);
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap  <= send_gap - 1;
            end else if (byte_backlog.size() > 0) begin
               req_valid   <= 1'b1;
               req_payload <= byte_backlog.pop_front();
               if (send_jitter && $urandom_range(0, 7) == 0)
                  send_gap <= $urandom_range(1, 13);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_char(rsp_payload);
         if (long_hold) begin
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else if (recv_jitter && $urandom_range(0, 9) == 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 12);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic add_byte(input logic [7:0] b, input logic fin);
      req_type item;
      item.in_byte        = b;
      item.last_of_string = fin;
      byte_backlog.push_back(item);
      queued_count++;
   endtask

   task automatic wait_idle;
      while (accepted_count != queued_count || expected_chars.size() != 0)
         @(posedge clock);
      // a half-open sequence leaves nothing to wait for
      repeat (4) @(posedge clock);
   endtask

   task automatic set_mode(input logic m);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      mode_shadow = m;
   endtask

   function automatic logic [30:0] notable_point(input int k);
      case (k)
         0:  return 31'h20AC;
         1:  return 31'h201A;
         2:  return 31'h0192;
         3:  return 31'h201E;
         4:  return 31'h2026;
         5:  return 31'h2020;
         6:  return 31'h2021;
         7:  return 31'h02C6;
         8:  return 31'h2030;
         9:  return 31'h0160;
         10: return 31'h2039;
         11: return 31'h0152;
         12: return 31'h017D;
         13: return 31'h2018;
         14: return 31'h2019;
         15: return 31'h201C;
         16: return 31'h201D;
         17: return 31'h2022;
         18: return 31'h2013;
         19: return 31'h2014;
         20: return 31'h02DC;
         21: return 31'h2122;
         22: return 31'h0161;
         23: return 31'h203A;
         24: return 31'h0153;
         25: return 31'h017E;
         26: return 31'h0178;
         27: return 31'h00B4;
         28: return 31'h00F4;
         29: return 31'h00E3;
         30: return 31'h00E9;
         31: return 31'h00C5;
         32: return 31'h00F8;
         33: return 31'h0081;
         default: return 31'h2000;
      endcase
   endfunction

   function automatic logic end_flag;
      return $urandom_range(0, 9) == 0;
   endfunction

   // one character: ASCII, noise, a whole sequence or a cut-short one
   task automatic add_random_char;
      int          pick;
      int          len;
      int          keep;
      logic [30:0] cp;
      logic [30:0] sh;
      logic [7:0]  b;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         add_byte(8'($urandom_range(0, 127)), end_flag());
      end else if (pick < 40) begin
         add_byte(8'($urandom_range(0, 255)), end_flag());
      end else begin
         case ($urandom_range(0, 3))
            0:       cp = notable_point($urandom_range(0, 34));
            1:       cp = 31'($urandom_range(8'h80, 8'hFF));
            2:       cp = 31'($urandom_range(0, 16'hFFFF));
            default: cp = 31'($urandom);
         endcase
         if (cp < 31'h800) len = 2;
         else if (cp < 31'h10000) len = 3;
         else if (cp < 31'h200000) len = 4;
         else if (cp < 31'h4000000) len = 5;
         else len = 6;
         // overlong forms now and then
         if ($urandom_range(0, 3) == 0) len += $urandom_range(0, 6 - len);
         keep = (pick >= 85) ? $urandom_range(1, len - 1) : len;
         for (int k = 0; k < keep; k++) begin
            sh = cp >> (6 * (len - 1 - k));
            if (k == 0) b = (8'hFF << (8 - len)) | (sh[7:0] & (8'h7F >> len));
            else b = 8'h80 | {2'b00, sh[5:0]};
            add_byte(b, (k == keep - 1) ? end_flag() : 1'b0);
         end
         if (pick >= 85 && $urandom_range(0, 1) == 1)
            add_byte(8'($urandom_range(0, 255)), end_flag());
      end
   endtask

   initial begin
      int target;
      close_sequence();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      set_mode(1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'h7F, 1'b0);
      add_byte(8'h80, 1'b0);
      add_byte(8'hFE, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'hC3, 1'b0);
      add_byte(8'hA9, 1'b0);
      add_byte(8'hE2, 1'b0);
      add_byte(8'h82, 1'b0);
      add_byte(8'hAC, 1'b0);
      // overlong zero
      add_byte(8'hC0, 1'b0);
      add_byte(8'h80, 1'b0);
      // six-byte lead broken after four continuations
      add_byte(8'hFD, 1'b0);
      repeat (4) add_byte(8'h80, 1'b0);
      add_byte(8'h41, 1'b0);
      // lead alone, then a sequence cut short at end of string
      add_byte(8'hC3, 1'b1);
      add_byte(8'hE2, 1'b0);
      add_byte(8'h82, 1'b1);
      wait_idle();

      set_mode(1'b1);
      add_byte(8'hC3, 1'b0);
      add_byte(8'hA9, 1'b0);
      add_byte(8'hE2, 1'b0);
      add_byte(8'h80, 1'b0);
      add_byte(8'h9C, 1'b1);
      // mode switched while a sequence is open
      add_byte(8'hE2, 1'b0);
      add_byte(8'h82, 1'b0);
      wait_idle();
      set_mode(1'b0);
      add_byte(8'hAC, 1'b1);
      wait_idle();

      for (int phase = 0; phase < 6; phase++) begin
         set_mode(1'($urandom_range(0, 1)));
         send_jitter <= (phase < 4 && phase != 3);
         recv_jitter <= (phase < 4 && phase != 1);
         if (phase == 2) long_hold <= 1'b1;
         target = queued_count + 37;
         while (queued_count < target) add_random_char();
         if (phase == 2) begin
            repeat (200) @(posedge clock);
            long_hold <= 1'b0;
         end
         wait_idle();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
